// ===== src/cfps_pkg.sv =====
// Shared types and constants for the CO2 frame parser.
package cfps_pkg;

  localparam int FRAME_BYTES_DEF = 16;

  localparam logic [7:0] SYNC_A = 8'h42;
  localparam logic [7:0] SYNC_B = 8'h4D;

  localparam logic [15:0] SPIKE_LIMIT_RST = 16'd100;
  localparam logic [15:0] WARMUP_CODE_RST = 16'd511;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPIKE_LIMIT = 1'b0,
    CFG_WARMUP_CODE = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_ACCEPT   = 2'd0,
    ST_SPIKE    = 2'd1,
    ST_NOTREADY = 2'd2,
    ST_BADHDR   = 2'd3
  } status_t;

  // One completed frame handed from the framer to the judge.
  typedef struct packed {
    logic        hdr_ok;
    logic [15:0] reading;
  } frame_evt_t;

endpackage

// ===== src/cfps_framer.sv =====
// Byte framer: position counter, resync detect, header and reading capture.
module cfps_framer import cfps_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       frm_valid,
  input  logic       frm_ready,
  output frame_evt_t frm
);

  localparam int POS_W = $clog2(FRAME_BYTES);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] POS_HI   = POS_W'(6);
  localparam logic [POS_W-1:0] POS_LO   = POS_W'(7);

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic [7:0]       hdr0;
  logic [7:0]       hdr1;
  logic [7:0]       rd_hi;
  logic [7:0]       rd_lo;
  logic [7:0]       prev;
  logic             accept;
  logic             resync;
  logic             done;
  logic [7:0]       lo_eff;

  assign in_ready = !frm_valid || frm_ready;
  assign accept   = in_valid && in_ready;

  assign resync = (pos > POS_W'(1)) && (rx_byte == SYNC_B) && (prev == SYNC_A);
  assign done   = !resync && (pos == LAST_POS);
  // Short frames end on the low reading byte itself
  assign lo_eff = (pos == POS_LO) ? rx_byte : rd_lo;

  always_comb begin
    if (resync) begin
      pos_next = POS_W'(2);
    end else if (done) begin
      pos_next = '0;
    end else begin
      pos_next = pos + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      frm_valid <= 1'b0;
    end else begin
      if (accept) begin
        pos <= pos_next;
      end
      if (accept && done) begin
        frm_valid <= 1'b1;
      end else if (frm_ready) begin
        frm_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prev <= rx_byte;
      if (resync) begin
        hdr0 <= SYNC_A;
        hdr1 <= SYNC_B;
      end else begin
        if (pos == '0)        hdr0  <= rx_byte;
        if (pos == POS_W'(1)) hdr1  <= rx_byte;
        if (pos == POS_HI)    rd_hi <= rx_byte;
        if (pos == POS_LO)    rd_lo <= rx_byte;
      end
      if (done) begin
        frm.hdr_ok  <= (hdr0 == SYNC_A) && (hdr1 == SYNC_B);
        frm.reading <= {rd_hi, lo_eff};
      end
    end
  end

endmodule

// ===== src/cfps_judge.sv =====
// Frame judge: warm-up and spike checks, filter state, result register.
module cfps_judge import cfps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  frm_valid,
  output logic                  frm_ready,
  input  frame_evt_t            frm,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            frame_status,
  output logic [15:0]           co2_reading
);

  logic [15:0] spike_limit;
  logic [15:0] warmup_code;
  logic [15:0] last_accepted;
  logic        ready_flag;
  logic [15:0] diff;
  logic        take;
  status_t     status;

  assign frm_ready = !out_valid || out_ready;
  assign take      = frm_valid && frm_ready;

  assign diff = (frm.reading >= last_accepted) ? (frm.reading - last_accepted)
                                               : (last_accepted - frm.reading);

  always_comb begin
    if (!frm.hdr_ok) begin
      status = ST_BADHDR;
    end else if (!ready_flag && (frm.reading == warmup_code)) begin
      status = ST_NOTREADY;
    end else if ((last_accepted == '0) || (diff < spike_limit)) begin
      status = ST_ACCEPT;
    end else begin
      status = ST_SPIKE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      spike_limit   <= SPIKE_LIMIT_RST;
      warmup_code   <= WARMUP_CODE_RST;
      last_accepted <= '0;
      ready_flag    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SPIKE_LIMIT: spike_limit <= cfg_data;
          CFG_WARMUP_CODE: warmup_code <= cfg_data;
          default: ;
        endcase
      end
      if (take && (status == ST_ACCEPT)) begin
        last_accepted <= frm.reading;
        ready_flag    <= 1'b1;
      end
      if (take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      frame_status <= status;
      co2_reading  <= (status == ST_BADHDR) ? 16'd0 : frm.reading;
    end
  end

endmodule

// ===== src/co2_frame_parser_with_spike_filter.sv =====
// Top level of the CO2 sensor frame parser with spike filter.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------
//  input    | in_valid / in_ready   | rx_byte[7:0]
//  output   | out_valid / out_ready | frame_status[1:0], co2_reading[15:0]
//  config   | cfg_we (no wait)      | cfg_index, cfg_data[15:0]
//
// One byte is taken per cycle while in_ready is high. The framer registers
// a finished frame when it takes its last byte; the judge registers the result
// when it takes that frame from the framer, which a stalled output can delay.
// rst (synchronous) clears the byte position, the filter history, the
// ready flag and both valid flags, and loads the register defaults.
// A stalled result holds the output register; the framer stage keeps
// taking bytes until its own frame slot is full and waiting.
module co2_frame_parser_with_spike_filter import cfps_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            rx_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            frame_status,
  output logic [15:0]           co2_reading,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // framer -> judge transaction
  logic       frm_valid;
  logic       frm_ready;
  frame_evt_t frm;

  // Position tracking, 0x42 0x4D resync, capture of header and bytes 6/7
  cfps_framer #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_framer (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .frm_valid (frm_valid),
    .frm_ready (frm_ready),
    .frm       (frm)
  );

  // Header verdict, warm-up test, spike filter and result register
  cfps_judge u_judge (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .frm_valid    (frm_valid),
    .frm_ready    (frm_ready),
    .frm          (frm),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_status (frame_status),
    .co2_reading  (co2_reading)
  );

endmodule

// ===== src/cfps_checker.sv =====
// Port-level checker for the CO2 frame parser, bound to the top level.
module cfps_checker import cfps_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  frame_status,
  input logic [15:0] co2_reading
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_status) && $stable(co2_reading))
    else $error("result changed while stalled");

  a_badhdr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (frame_status == ST_BADHDR) |-> co2_reading == 16'd0)
    else $error("bad header result carries a reading");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // A fresh result follows an accepted input byte
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a frame-ending byte");

endmodule

bind co2_frame_parser_with_spike_filter cfps_checker u_cfps_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .frame_status (frame_status),
  .co2_reading  (co2_reading)
);
